// ===== rtl/bm3_pkg.sv =====
`default_nettype none

package bm3_pkg;

	localparam int FW_W = 11;
	localparam int FH_W = 16;
	localparam int CNT_W = FW_W + FH_W;
	localparam int DIV_CW = $clog2(CNT_W + 1);

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_OP_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SE_MASK      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIFF_ENABLE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

	localparam logic            OP_MODE_RST      = 1'b1;
	localparam logic [8:0]      SE_MASK_RST      = 9'd79;
	localparam logic            DIFF_ENABLE_RST  = 1'b1;
	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd768;

	localparam logic [FW_W-1:0] FW_MIN = 11'd3;
	localparam logic [FH_W-1:0] FH_MIN = 16'd3;

	localparam logic MODE_ERODE = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	localparam logic [8:0] WIN_KEEP = 9'h0DB;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = 2;

	typedef struct packed {
		logic cmd;
		logic pixel_in;
	} in_word_t;

	typedef struct packed {
		logic pixel_out;
		logic frame_last;
	} out_word_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [CNT_W-1:0] quot;
		logic [FW_W-1:0]  rem;
	} div_stat_t;

	function automatic logic [8:0] reverse9(input logic [8:0] m);
		logic [8:0] r;
		r = '0;
		for (int k = 0; k < 9; k++) begin
			r[8-k] = m[k];
		end
		return r;
	endfunction

	function automatic logic morph(input logic [8:0] win, input logic [8:0] mask,
			input logic mode);
		logic res;
		if (mode == MODE_ERODE) begin
			res = ((win & mask) == mask) ? 1'b0 : 1'b1;
		end else begin
			res = ((win & reverse9(mask)) != 9'd0) ? 1'b0 : 1'b1;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/binary_morphology_3x3_top.sv =====
// a result word is formed from the stage-1 registers and written into the output queue
// throughput: one word per cycle unless the divider or a full output queue stalls input,
// set by the single read and write port of the line memory; a four-word output queue
// keeps input flowing while the output side stalls; a frame_width write holds off input
// while a serial divider re-derives the output row and column; arst_n clears counters and
// loads register defaults, the line memory is not cleared
`default_nettype none

module binary_morphology_3x3_top import bm3_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  pix_valid,
	output logic                       pix_ready,
	input  wire in_word_t              pix_data,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output out_word_t                  res_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int FW_MAX = (1 << FW_W) - 1;
	localparam int WCAP = (MAX_WIDTH < FW_MAX) ? MAX_WIDTH : FW_MAX;
	localparam logic [FW_W-1:0] WCAP_V = FW_W'(WCAP);

	logic            op_mode_q;
	logic [8:0]      se_mask_q;
	logic            diff_en_q;
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;
	logic            wpend_q;

	logic [AW-1:0]    in_column_q;
	logic [FH_W-1:0]  in_row_q;
	logic [CNT_W-1:0] out_count_q;
	logic [CNT_W-1:0] r_q;
	logic [AW-1:0]    c_q;

	logic [FW_W-1:0] w_eff;
	logic [FH_W-1:0] h_eff;
	logic [AW-1:0]   wm1;
	logic [FH_W-1:0] hm1;

	div_stat_t div_stat;
	logic      fifo_room;
	logic      busy;
	logic      accept;
	logic      is_flush;
	logic      frame_in;
	logic      do_pix;
	logic      do_flush;
	logic      do_emit;
	logic      pix_emit;
	logic      pos_last;
	logic      interior;
	logic      sel_a;
	logic [AW-1:0] col_idx;
	logic [AW-1:0] rd_addr;

	logic          wr_s1;
	logic          emit_s1;
	logic          flush_s1;
	logic          pix_s1;
	logic [AW-1:0] addr_s1;
	logic          sel_a_s1;
	logic          interior_s1;
	logic          last_s1;
	logic          fwd_q;
	logic [1:0]    fwd_word_q;
	logic [1:0]    mem_word;
	logic [1:0]    eff_word;
	logic [1:0]    wr_word;
	logic          ta;
	logic          tb;
	logic [8:0]    win_q;
	logic [8:0]    win_next;
	logic          centre;
	logic          res;
	out_word_t     push_word;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q <= OP_MODE_RST;
			se_mask_q <= SE_MASK_RST;
			diff_en_q <= DIFF_ENABLE_RST;
			frame_width_q <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			wpend_q <= 1'b0;
		end else begin
			wpend_q <= cfg_we && (cfg_index == REG_FRAME_WIDTH);
			if (cfg_we) begin
				case (cfg_index)
					REG_OP_MODE: begin
						op_mode_q <= cfg_data[0];
					end
					REG_SE_MASK: begin
						se_mask_q <= cfg_data[8:0];
					end
					REG_DIFF_ENABLE: begin
						diff_en_q <= cfg_data[0];
					end
					REG_FRAME_WIDTH: begin
						frame_width_q <= cfg_data[FW_W-1:0];
					end
					REG_FRAME_HEIGHT: begin
						frame_height_q <= cfg_data[FH_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign w_eff = (frame_width_q < FW_MIN) ? FW_MIN :
		((frame_width_q > WCAP_V) ? WCAP_V : frame_width_q);
	assign h_eff = (frame_height_q < FH_MIN) ? FH_MIN : frame_height_q;
	assign wm1 = AW'(w_eff - FW_W'(1));
	assign hm1 = h_eff - FH_W'(1);

	bm3_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (wpend_q),
		.dividend (out_count_q),
		.divisor  (w_eff),
		.stat     (div_stat)
	);

	// stage 0: position bookkeeping and memory read
	assign busy = wpend_q || div_stat.busy || div_stat.done;
	assign pix_ready = !busy && fifo_room;
	assign accept = pix_valid && pix_ready;
	assign is_flush = pix_data.cmd == CMD_FLUSH;
	assign frame_in = in_row_q >= h_eff;
	assign do_pix = accept && !is_flush && !frame_in;
	assign do_flush = accept && is_flush && frame_in;
	assign pix_emit = (in_row_q >= FH_W'(2)) || ((in_row_q == FH_W'(1)) && (in_column_q != '0));
	assign do_emit = (do_pix && pix_emit) || do_flush;
	assign col_idx = (in_column_q <= wm1) ? in_column_q : wm1;
	assign rd_addr = is_flush ? c_q : col_idx;
	assign pos_last = (r_q >= CNT_W'(h_eff)) || ((r_q == CNT_W'(hm1)) && (c_q == wm1));
	assign interior = (r_q != '0) && (r_q < CNT_W'(hm1)) && (c_q != '0) && (c_q < wm1);
	assign sel_a = r_q >= CNT_W'(hm1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_column_q <= '0;
			in_row_q <= '0;
			out_count_q <= '0;
			r_q <= '0;
			c_q <= '0;
		end else if (div_stat.done) begin
			r_q <= div_stat.quot;
			c_q <= AW'(div_stat.rem);
		end else if (do_emit && pos_last) begin
			in_column_q <= '0;
			in_row_q <= '0;
			out_count_q <= '0;
			r_q <= '0;
			c_q <= '0;
		end else begin
			if (do_pix) begin
				if (in_column_q >= wm1) begin
					in_column_q <= '0;
					in_row_q <= in_row_q + FH_W'(1);
				end else begin
					in_column_q <= in_column_q + AW'(1);
				end
			end
			if (do_emit) begin
				out_count_q <= out_count_q + CNT_W'(1);
				if (c_q == wm1) begin
					c_q <= '0;
					r_q <= r_q + CNT_W'(1);
				end else begin
					c_q <= c_q + AW'(1);
				end
			end
		end
	end

	bm3_line_mem #(
		.DEPTH (MAX_WIDTH)
	) u_line_mem (
		.clk   (clk),
		.we    (wr_s1),
		.waddr (addr_s1),
		.wdata (wr_word),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (mem_word)
	);

	// stage 1: window update, write-back and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
			emit_s1 <= 1'b0;
			flush_s1 <= 1'b0;
			fwd_q <= 1'b0;
			win_q <= '0;
		end else begin
			wr_s1 <= do_pix;
			emit_s1 <= do_emit;
			flush_s1 <= do_flush;
			// write-back of the previous word lands on the entry being read
			fwd_q <= wr_s1 && (addr_s1 == rd_addr);
			if (wr_s1) begin
				win_q <= win_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_word_q <= wr_word;
		if (accept) begin
			pix_s1 <= pix_data.pixel_in;
			addr_s1 <= rd_addr;
			sel_a_s1 <= sel_a;
			interior_s1 <= interior && !is_flush;
			last_s1 <= pos_last;
		end
	end

	assign eff_word = fwd_q ? fwd_word_q : mem_word;
	assign ta = eff_word[0];
	assign tb = eff_word[1];
	assign wr_word = {ta, pix_s1};

	always_comb begin
		win_next = (win_q >> 1) & WIN_KEEP;
		win_next[2] = tb;
		win_next[5] = ta;
		win_next[8] = pix_s1;
	end

	assign centre = flush_s1 ? (sel_a_s1 ? ta : tb) : win_next[4];
	assign res = interior_s1 ? morph(win_next, se_mask_q, op_mode_q) : centre;
	assign push_word.pixel_out = diff_en_q ? (centre ^ res) : res;
	assign push_word.frame_last = last_s1;

	bm3_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit_s1),
		.push_data (push_word),
		.pend      (emit_s1),
		.room      (fifo_room),
		.valid     (res_valid),
		.ready     (res_ready),
		.data      (res_data)
	);

endmodule

`default_nettype wire

// ===== rtl/bm3_line_mem.sv =====
`default_nettype none

module bm3_line_mem #(
	parameter int DEPTH = 1024,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [1:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [1:0]    rdata
);

	// bit 0 holds the previous line, bit 1 the line before it
	logic [1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bm3_div.sv =====
`default_nettype none

module bm3_div import bm3_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [CNT_W-1:0] dividend,
	input  wire logic [FW_W-1:0]  divisor,
	output div_stat_t             stat
);

	logic [CNT_W-1:0]  num_q;
	logic [FW_W-1:0]   rem_q;
	logic [FW_W-1:0]   den_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [FW_W:0]     trial;
	logic              ge;

	assign trial = {rem_q, num_q[CNT_W-1]};
	assign ge = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= DIV_CW'(CNT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CW'(1);
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[CNT_W-2:0], ge};
			rem_q <= ge ? FW_W'(trial - {1'b0, den_q}) : trial[FW_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.quot = num_q;
	assign stat.rem = rem_q;

endmodule

`default_nettype wire

// ===== rtl/bm3_out_fifo.sv =====
`default_nettype none

module bm3_out_fifo import bm3_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire out_word_t push_data,
	input  wire logic      pend,
	output logic           room,
	output logic           valid,
	input  wire logic      ready,
	output out_word_t      data
);

	out_word_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q;
	logic [FIFO_AW-1:0] rptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               pop;

	assign valid = count_q != '0;
	assign pop = valid && ready;
	assign data = mem_q[rptr_q];
	// a word still in flight toward the queue holds its slot
	assign room = (count_q + (FIFO_AW+1)'(pend)) < (FIFO_AW+1)'(FIFO_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire
